// File: rtl/core/swst_pkg.sv
// ----------------------------------------------------------------------------
// swst_pkg: shared types and codes for the sliding window slot tracker
// Holds the command codes and the packed command and result words.
// ----------------------------------------------------------------------------
package swst_pkg;

  localparam int unsigned SegW = 16;
  localparam int unsigned SlotW = 5;
  localparam int unsigned CntW = 6;

  typedef enum logic [2:0] {
    CMD_SET_BASE = 3'd0,
    CMD_ADVANCE  = 3'd1,
    CMD_MARK     = 3'd2,
    CMD_UNMARK   = 3'd3,
    CMD_QUERY    = 3'd4,
    CMD_LIST     = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [SegW-1:0] segment;
    logic [SegW-1:0] amount;
    logic [7:0]      max_count;
  } cmd_word_t;

  typedef struct packed {
    logic             has_slot;
    logic             in_use;
    logic [SlotW-1:0] slot_index;
    logic [SegW-1:0]  base_segment;
    logic [CntW-1:0]  in_use_count;
    logic [SegW-1:0]  listed_segment;
    logic             listed_valid;
    logic             last;
  } res_word_t;

endpackage

// File: rtl/core/swst_locate.sv
// ----------------------------------------------------------------------------
// swst_locate: shared window offset and ring slot unit
// Maps a sequence number to its offset from the base and its ring slot.
// ----------------------------------------------------------------------------
module swst_locate
  import swst_pkg::*;
#(
  parameter int unsigned SlotBits = 5
) (
  input  logic [SegW-1:0]     seg_i,
  input  logic [SegW-1:0]     base_i,
  input  logic [SlotBits-1:0] ring_start_i,
  input  logic [SlotBits:0]   win_i,
  output logic                inside_o,
  output logic [SlotBits-1:0] slot_o
);

  logic [SegW-1:0]   off;
  logic [SlotBits:0] sum;

  always_comb begin
    off = seg_i - base_i;
    inside_o = (off < SegW'(win_i));
    // both terms are below win, so one subtract folds the sum
    sum = {1'b0, ring_start_i} + off[SlotBits:0];
    if (sum >= win_i) begin
      sum = sum - win_i;
    end
    slot_o = inside_o ? sum[SlotBits-1:0] : '0;
  end

endmodule

// File: rtl/core/sliding_window_slot_tracker.sv
// ----------------------------------------------------------------------------
// sliding_window_slot_tracker: sequence window with marked slots in mark order
// Top level: command sequencer, link store and result strobe.
// ----------------------------------------------------------------------------
// A command word is taken when start_i is high and busy_o low. busy_o drops in
// the cycle that shows the command's last result word, so the next word can be
// taken at the edge that ends that cycle. Each result word appears on res_o for
// one cycle with res_valid_o high, and the receiver cannot stall it.
// Set_base, mark, unmark, query, empty list and unknown commands pass from one
// accepted word through an execute state and a result state, and the result
// word is then shown while idle. Advance with a step of 1 to W walks one
// sequence number per cycle through the shared locate unit; a larger step
// resets the window from the execute state. A list of n entries follows the
// link chain one entry per cycle. The window size register may only be written
// while busy_o is low; the write is registered and clears every mark.
// ----------------------------------------------------------------------------
module sliding_window_slot_tracker
  import swst_pkg::*;
#(
  parameter int unsigned WINDOW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  cmd_word_t       cmd_i,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  output logic            res_valid_o,
  output res_word_t       res_o
);

  localparam int unsigned SB = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_ADV  = 5'b00100,
    ST_LIST = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  cmd_word_t cw_q;
  logic [SegW-1:0] base_q;
  logic [SB-1:0] rs_q;
  logic [WINDOW-1:0] marked_q;
  logic [SB-1:0] next_q [WINDOW];
  logic [SB-1:0] prev_q [WINDOW];
  logic [SB-1:0] head_q, tail_q;
  logic [SB:0] cnt_q;
  logic [SB:0] win_q;
  logic [SegW-1:0] step_q;
  logic [SB-1:0] cur_q;
  logic [7:0] left_q;
  logic res_valid_q;
  res_word_t res_q;
  res_word_t res_d;

  logic [SegW-1:0] loc_seg;
  logic loc_in;
  logic [SB-1:0] loc_slot;
  logic [SB:0] off_w;
  logic [SB:0] lst_off;
  logic [SB:0] n_list;

  // one locate unit serves query, mark, unmark and each advance step;
  // the advance walk always drops the slot at the current base
  always_comb begin
    loc_seg = (state_q == ST_ADV) ? base_q : cw_q.segment;
  end

  swst_locate #(.SlotBits(SB)) u_loc (
    .seg_i       (loc_seg),
    .base_i      (base_q),
    .ring_start_i(rs_q),
    .win_i       (win_q),
    .inside_o    (loc_in),
    .slot_o      (loc_slot)
  );

  always_comb begin
    // listed offset: (cur - ring_start) mod W
    off_w = {1'b0, cur_q} + win_q - {1'b0, rs_q};
    if (off_w >= win_q) begin
      off_w = off_w - win_q;
    end
    lst_off = off_w;
    // list length: min(mark count, max_count)
    n_list = cnt_q;
    if (32'(cnt_q) > 32'(cw_q.max_count)) begin
      n_list = (SB+1)'(cw_q.max_count);
    end
  end

  // result word for the list and done states
  always_comb begin
    res_d = '0;
    res_d.base_segment = base_q;
    res_d.in_use_count = CntW'(cnt_q);
    res_d.last = 1'b1;
    if (state_q == ST_LIST) begin
      res_d.listed_segment = base_q + SegW'(lst_off);
      res_d.listed_valid = 1'b1;
      res_d.last = (left_q == 8'd1);
    end else if (cw_q.cmd == CMD_QUERY) begin
      res_d.has_slot = loc_in;
      res_d.in_use = loc_in && marked_q[loc_slot];
      res_d.slot_index = SlotW'(loc_slot);
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = start_i ? ST_EXEC : ST_IDLE;
      ST_EXEC: begin
        if (cw_q.cmd == CMD_ADVANCE && cw_q.amount != '0
            && cw_q.amount <= SegW'(win_q)) state_d = ST_ADV;
        else if (cw_q.cmd == CMD_LIST && n_list != '0) state_d = ST_LIST;
        else state_d = ST_DONE;
      end
      ST_ADV:  state_d = (step_q == SegW'(1)) ? ST_DONE : ST_ADV;
      ST_LIST: state_d = (left_q == 8'd1) ? ST_IDLE : ST_LIST;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cw_q <= '0;
      base_q <= '0;
      rs_q <= '0;
      marked_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      cnt_q <= '0;
      win_q <= (SB+1)'(WINDOW);
      step_q <= '0;
      cur_q <= '0;
      left_q <= '0;
      res_valid_q <= 1'b0;
      res_q <= '0;
    end else begin
      res_valid_q <= (state_q == ST_LIST) || (state_q == ST_DONE);
      if (cfg_we_i) begin
        // clamp into 1..WINDOW and drop all marks
        if (cfg_wdata_i == '0) win_q <= (SB+1)'(1);
        else if (32'(cfg_wdata_i) > WINDOW) win_q <= (SB+1)'(WINDOW);
        else win_q <= (SB+1)'(cfg_wdata_i);
        rs_q <= '0;
        marked_q <= '0;
        head_q <= '0;
        tail_q <= '0;
        cnt_q <= '0;
      end
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            cw_q <= cmd_i;
            step_q <= '0;
          end
        end
        ST_EXEC: begin
          unique case (cw_q.cmd)
            CMD_SET_BASE: begin
              base_q <= cw_q.segment;
              rs_q <= '0;
              marked_q <= '0;
              head_q <= '0;
              tail_q <= '0;
              cnt_q <= '0;
            end
            CMD_ADVANCE: begin
              if (cw_q.amount > SegW'(win_q)) begin
                base_q <= base_q + cw_q.amount;
                rs_q <= '0;
                marked_q <= '0;
                head_q <= '0;
                tail_q <= '0;
                cnt_q <= '0;
              end else begin
                step_q <= cw_q.amount;
              end
            end
            CMD_MARK: begin
              if (loc_in && !marked_q[loc_slot]) begin
                marked_q[loc_slot] <= 1'b1;
                if (cnt_q == '0) begin
                  head_q <= loc_slot;
                end else begin
                  next_q[tail_q] <= loc_slot;
                  prev_q[loc_slot] <= tail_q;
                end
                tail_q <= loc_slot;
                cnt_q <= cnt_q + (SB+1)'(1);
              end
            end
            CMD_UNMARK: begin
              if (loc_in && marked_q[loc_slot]) begin
                marked_q[loc_slot] <= 1'b0;
                if (loc_slot != head_q) next_q[prev_q[loc_slot]] <= next_q[loc_slot];
                if (loc_slot != tail_q) prev_q[next_q[loc_slot]] <= prev_q[loc_slot];
                if (cnt_q == (SB+1)'(1)) begin
                  head_q <= '0;
                  tail_q <= '0;
                end else begin
                  if (loc_slot == head_q) head_q <= next_q[loc_slot];
                  if (loc_slot == tail_q) tail_q <= prev_q[loc_slot];
                end
                cnt_q <= cnt_q - (SB+1)'(1);
              end
            end
            CMD_LIST: begin
              cur_q <= head_q;
              left_q <= 8'(n_list);
            end
            default: ;
          endcase
        end
        ST_ADV: begin
          // drop the mark at the current base, then advance base and ring start
          if (loc_in && marked_q[loc_slot]) begin
            marked_q[loc_slot] <= 1'b0;
            if (loc_slot != head_q) next_q[prev_q[loc_slot]] <= next_q[loc_slot];
            if (loc_slot != tail_q) prev_q[next_q[loc_slot]] <= prev_q[loc_slot];
            if (cnt_q == (SB+1)'(1)) begin
              head_q <= '0;
              tail_q <= '0;
            end else begin
              if (loc_slot == head_q) head_q <= next_q[loc_slot];
              if (loc_slot == tail_q) tail_q <= prev_q[loc_slot];
            end
            cnt_q <= cnt_q - (SB+1)'(1);
          end
          step_q <= step_q - SegW'(1);
          base_q <= base_q + SegW'(1);
          if ({1'b0, rs_q} + (SB+1)'(1) >= win_q) rs_q <= '0;
          else rs_q <= rs_q + SB'(1);
        end
        ST_LIST: begin
          res_q <= res_d;
          cur_q <= next_q[cur_q];
          left_q <= left_q - 8'd1;
        end
        ST_DONE: begin
          res_q <= res_d;
        end
        default: ;
      endcase
    end
  end

  // every result word comes while the block is busy or just after
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o)) else $error("result word outside a command");
  // the mark count never exceeds the window
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= win_q) else $error("mark count above window");
  // no command is taken while a list is running
  a_list_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIST |-> busy_o) else $error("list not busy");

endmodule
